// ===== src/kmds_pkg.sv =====
// shared types, constants and helpers for the key matrix debounce scanner
// no dependencies; every other file in src uses this package by scoped names
package kmds_pkg;

	localparam int MATRIX_SIZE = 8;
	localparam int NUM_KEYS    = MATRIX_SIZE * MATRIX_SIZE;
	localparam int ROW_W       = $clog2(MATRIX_SIZE);
	localparam int COL_W       = $clog2(MATRIX_SIZE);
	localparam int CNT_W       = $clog2(MATRIX_SIZE + 1);
	localparam int KEY_W       = $clog2(NUM_KEYS);

	localparam logic [3:0]       ROW_LIMIT = 4'(MATRIX_SIZE);
	localparam logic [CNT_W-1:0] COL_COUNT = CNT_W'(MATRIX_SIZE);

	localparam logic [7:0] HIST_ALL_LOW  = 8'h00;
	localparam logic [7:0] HIST_ALL_HIGH = 8'hff;

	typedef struct packed {
		logic [2:0] row_number;
		logic [7:0] column_bits;
	} row_item_t;

	typedef struct packed {
		logic [5:0] key_index;
		logic       pressed;
		logic       last;
	} key_event_t;

	// controller to datapath
	typedef struct packed {
		logic             load;
		logic             rd_en;
		logic [COL_W-1:0] rd_col;
		logic             eval_en;
		logic [COL_W-1:0] eval_col;
		logic             flush;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic evt;
		logic pend_valid;
		logic out_free;
	} dp_status_t;

	function automatic logic [KEY_W-1:0] key_addr(input logic [ROW_W-1:0] row,
			input logic [COL_W-1:0] col);
		key_addr = KEY_W'(row) * KEY_W'(MATRIX_SIZE) + KEY_W'(col);
	endfunction

endpackage

// ===== src/kmds_ctrl.sv =====
// sequencer for the key matrix debounce scanner: row accept, column walk, writeback
// depends on kmds_pkg
module kmds_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                row_valid,
	output logic                row_stall,
	input  logic [2:0]          row_number,
	input  kmds_pkg::dp_status_t st,
	output kmds_pkg::ctrl_cmd_t  cmd
);

	typedef enum logic [1:0] {
		IDLE,
		RUN,
		DONE
	} state_t;

	state_t                      state_q;
	logic [kmds_pkg::CNT_W-1:0]  rd_cnt_q;
	logic [kmds_pkg::COL_W-1:0]  eval_col_s1;
	logic                        eval_vld_s1;

	logic issue_active;
	logic blocked;
	logic advance;
	logic accept;
	logic in_range;

	assign row_stall    = (state_q != IDLE);
	assign accept       = row_valid && (state_q == IDLE);
	assign in_range     = ({1'b0, row_number} < kmds_pkg::ROW_LIMIT);
	assign issue_active = (rd_cnt_q < kmds_pkg::COL_COUNT);
	// an event found while one is pending needs the output register
	assign blocked      = eval_vld_s1 && st.evt && st.pend_valid && !st.out_free;
	assign advance      = (state_q == RUN) && !blocked;

	always_comb begin
		cmd.load     = accept && in_range;
		cmd.rd_en    = advance && issue_active;
		cmd.rd_col   = rd_cnt_q[kmds_pkg::COL_W-1:0];
		cmd.eval_en  = advance && eval_vld_s1;
		cmd.eval_col = eval_col_s1;
		cmd.flush    = (state_q == DONE) && (!st.pend_valid || st.out_free);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			rd_cnt_q    <= '0;
			eval_col_s1 <= '0;
			eval_vld_s1 <= 1'b0;
		end else begin
			unique case (state_q)
				IDLE: begin
					if (accept && in_range) begin
						state_q     <= RUN;
						rd_cnt_q    <= '0;
						eval_vld_s1 <= 1'b0;
					end
				end
				RUN: begin
					if (advance) begin
						eval_vld_s1 <= issue_active;
						eval_col_s1 <= rd_cnt_q[kmds_pkg::COL_W-1:0];
						if (issue_active) begin
							rd_cnt_q <= rd_cnt_q + 1'b1;
						end else begin
							state_q <= DONE;
						end
					end
				end
				DONE: begin
					if (cmd.flush) begin
						state_q <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

endmodule

// ===== src/kmds_datapath.sv =====
// datapath of the key matrix debounce scanner: key state, history memory, event output
// depends on kmds_pkg
module kmds_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  kmds_pkg::row_item_t  row_data,
	input  kmds_pkg::ctrl_cmd_t  cmd,
	output kmds_pkg::dp_status_t st,
	output logic                 evt_valid,
	input  logic                 evt_stall,
	output kmds_pkg::key_event_t evt_data
);

	localparam int MS = kmds_pkg::MATRIX_SIZE;

	logic [MS-1:0]              stable_q [MS];
	logic [MS-1:0]              flags_q  [MS];
	logic [kmds_pkg::ROW_W-1:0] row_q;
	logic [MS-1:0]              cols_q;
	logic [MS-1:0]              wflags_q;
	logic [MS-1:0]              wstab_q;

	logic [7:0]                 hist_mem [kmds_pkg::NUM_KEYS];
	logic [kmds_pkg::NUM_KEYS-1:0] hvalid_q;
	logic [7:0]                 hist_s1;
	logic                       hvld_s1;

	logic                       pend_vld_q;
	logic [5:0]                 pend_key_q;
	logic                       pend_press_q;
	logic                       out_vld_q;
	kmds_pkg::key_event_t       out_q;

	logic [kmds_pkg::ROW_W-1:0] row_idx;
	logic [MS-1:0]              cols_in;
	logic [7:0]                 hist_old;
	logic [7:0]                 hist_new;
	logic                       flagged;
	logic                       stab_bit;
	logic                       press;
	logic                       release_evt;
	logic                       evt;
	logic [kmds_pkg::KEY_W-1:0] eval_key;
	logic [kmds_pkg::KEY_W-1:0] rd_key;
	logic                       push;
	kmds_pkg::key_event_t       push_data;

	assign row_idx  = row_data.row_number[kmds_pkg::ROW_W-1:0];
	assign cols_in  = row_data.column_bits[MS-1:0];
	// never written entries read as all ones
	assign hist_old = hvld_s1 ? hist_s1 : kmds_pkg::HIST_ALL_HIGH;
	assign hist_new = {hist_old[6:0], cols_q[cmd.eval_col]};
	assign flagged  = wflags_q[cmd.eval_col];
	assign stab_bit = wstab_q[cmd.eval_col];
	assign press       = flagged && (hist_new == kmds_pkg::HIST_ALL_LOW) && stab_bit;
	assign release_evt = flagged && (hist_new == kmds_pkg::HIST_ALL_HIGH) && !stab_bit;
	assign evt      = press || release_evt;
	assign eval_key = kmds_pkg::key_addr(row_q, cmd.eval_col);
	assign rd_key   = kmds_pkg::key_addr(row_q, cmd.rd_col);

	assign st.evt        = evt;
	assign st.pend_valid = pend_vld_q;
	assign st.out_free   = !out_vld_q || !evt_stall;

	assign push = (cmd.eval_en && evt && pend_vld_q) || (cmd.flush && pend_vld_q);
	always_comb begin
		push_data.key_index = pend_key_q;
		push_data.pressed   = pend_press_q;
		push_data.last      = cmd.flush;
	end

	assign evt_valid = out_vld_q;
	assign evt_data  = out_q;

	// history memory, one port written at the evaluated key, one read ahead
	always_ff @(posedge clk) begin
		if (cmd.eval_en && flagged) begin
			hist_mem[eval_key] <= hist_new;
		end
		if (cmd.rd_en) begin
			hist_s1 <= hist_mem[rd_key];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MS; i++) begin
				stable_q[i] <= '1;
				flags_q[i]  <= '0;
			end
			hvalid_q   <= '0;
			hvld_s1    <= 1'b0;
			pend_vld_q <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			if (cmd.eval_en && flagged) begin
				hvalid_q[eval_key] <= 1'b1;
			end
			if (cmd.rd_en) begin
				hvld_s1 <= hvalid_q[rd_key];
			end
			if (cmd.flush) begin
				stable_q[row_q] <= wstab_q;
				flags_q[row_q]  <= wflags_q;
			end
			if (cmd.eval_en && evt) begin
				pend_vld_q <= 1'b1;
			end else if (cmd.flush) begin
				pend_vld_q <= 1'b0;
			end
			if (push) begin
				out_vld_q <= 1'b1;
			end else if (!evt_stall) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			row_q    <= row_idx;
			cols_q   <= cols_in;
			wflags_q <= flags_q[row_idx] | (cols_in ^ stable_q[row_idx]);
			wstab_q  <= stable_q[row_idx];
		end
		if (cmd.eval_en && evt) begin
			wstab_q[cmd.eval_col]  <= ~stab_bit;
			wflags_q[cmd.eval_col] <= 1'b0;
			pend_key_q   <= 6'(eval_key);
			pend_press_q <= press;
		end
		if (push) begin
			out_q <= push_data;
		end
	end

endmodule

// ===== src/key_matrix_debounce_scanner_top.sv =====
// top level of the key matrix debounce scanner
// depends on kmds_pkg, kmds_ctrl and kmds_datapath
//
// one beat on the row channel carries a scanned matrix row: its number and its
// active-low column lines. every key of the matrix keeps a stable state, a change
// flag and an eight-sample history; a column that differs from its stable value
// raises the flag, and each flagged column (ascending) shifts its current bit into
// its history. eight lows on a released key give a press beat, eight highs on a
// pressed key give a release beat, with last set on the final beat of the row.
// a row inside the matrix goes from accept to the next accept through the accept
// cycle, the column walk through the history memory (one column per cycle unless
// an event waits on a stalled output register, read one column ahead of the write),
// a drain and a writeback; a waiting event also holds the writeback. a row number
// outside the matrix is accepted and dropped.
// the history memory needs no clearing pass: per-key valid bits cleared at reset
// make an unwritten entry read as all ones.

module key_matrix_debounce_scanner_top (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 row_valid,
	output logic                 row_stall,
	input  kmds_pkg::row_item_t  row_data,
	output logic                 evt_valid,
	input  logic                 evt_stall,
	output kmds_pkg::key_event_t evt_data
);

	// command and status between sequencer and datapath
	kmds_pkg::ctrl_cmd_t  cmd;
	kmds_pkg::dp_status_t st;

	// sequencer: accept, column counter, read-ahead stage, writeback
	kmds_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.row_valid  (row_valid),
		.row_stall  (row_stall),
		.row_number (row_data.row_number),
		.st         (st),
		.cmd        (cmd)
	);

	// datapath: per-row state, history memory, pending event and output register
	kmds_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.row_data  (row_data),
		.cmd       (cmd),
		.st        (st),
		.evt_valid (evt_valid),
		.evt_stall (evt_stall),
		.evt_data  (evt_data)
	);

endmodule

// ===== src/kmds_checker.sv =====
// port-level checks for the key matrix debounce scanner, bound to the top level
// depends on kmds_pkg and key_matrix_debounce_scanner_top
module kmds_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 row_valid,
	input logic                 row_stall,
	input kmds_pkg::row_item_t  row_data,
	input logic                 evt_valid,
	input logic                 evt_stall,
	input kmds_pkg::key_event_t evt_data
);

	// a stalled event beat holds
	a_evt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && evt_stall |=> evt_valid && $stable(evt_data))
		else $error("event beat changed while stalled");

	// a row inside the matrix keeps the block busy next cycle
	a_row_busy: assert property (@(posedge clk) disable iff (!arst_n)
		row_valid && !row_stall && ({1'b0, row_data.row_number} < kmds_pkg::ROW_LIMIT)
		|=> row_stall)
		else $error("row inside matrix did not start a scan");

	// a row outside the matrix is dropped at once
	a_row_drop: assert property (@(posedge clk) disable iff (!arst_n)
		row_valid && !row_stall && ({1'b0, row_data.row_number} >= kmds_pkg::ROW_LIMIT)
		|=> !row_stall)
		else $error("row outside matrix held the block");

	// events are only produced while a row is being scanned
	a_evt_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(evt_valid) |-> $past(row_stall))
		else $error("event beat appeared while idle");

endmodule

bind key_matrix_debounce_scanner_top kmds_checker u_kmds_checker (.*);
